/* rtl/core/frdp_pkg.sv */
// Shared types, constants and character helpers for the framed decimal record parser.
// No dependencies; every other file of the block imports this package.

package frdp_pkg;

	// Parameter defaults
	localparam int BUFFER_BYTES_DEF = 32;
	localparam int FIELD_COUNT_DEF  = 6;

	// Fixed result shape
	localparam int OUT_FIELDS = 6;
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_MARKER = 1'b0,
		REG_END_MARKER   = 1'b1
	} cfg_reg_t;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h3C;
	localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h3E;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

	// Controller states
	typedef enum logic [1:0] {
		ST_RECV,
		ST_PARSE,
		ST_FINISH
	} state_t;

	// Control from the controller to the token scanner
	typedef struct packed {
		logic clear;
		logic vld;
	} scan_ctl_t;

	// Token scanner phase
	typedef enum logic [1:0] {
		PH_LEAD,
		PH_DIGITS,
		PH_STOP
	} phase_t;

	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [BYTE_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

/* rtl/core/frdp_if.sv */
// Valid/ready channel interfaces for the byte input and the record result.
// Depends on frdp_pkg for widths.

interface frdp_rx_if import frdp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frdp_res_if import frdp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] selected_output;
	logic [BYTE_W-1:0] cpu_util;
	logic [BYTE_W-1:0] ram_util;
	logic [BYTE_W-1:0] cpu_temp;
	logic [BYTE_W-1:0] gpu_temp;
	logic [BYTE_W-1:0] manual_value;
	logic [CNT_W-1:0]  tokens_found;

	modport source (output valid, output selected_output, output cpu_util, output ram_util,
		output cpu_temp, output gpu_temp, output manual_value, output tokens_found,
		input ready);
	modport sink   (input valid, input selected_output, input cpu_util, input ram_util,
		input cpu_temp, input gpu_temp, input manual_value, input tokens_found,
		output ready);
endinterface

/* rtl/core/frdp_scan.sv */
// Token scanner: consumes one record byte per cycle, splits on commas and
// converts each token to an 8-bit decimal value. Depends on frdp_pkg.

module frdp_scan import frdp_pkg::*; #(
	parameter int FIELD_COUNT = FIELD_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scan_ctl_t         ctl,
	input  logic [BYTE_W-1:0] data,
	output logic [BYTE_W-1:0] fields [OUT_FIELDS],
	output logic [CNT_W-1:0]  tokens
);

	localparam int TOKEN_LIMIT = (FIELD_COUNT < OUT_FIELDS) ? FIELD_COUNT : OUT_FIELDS;
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(TOKEN_LIMIT);
	localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(TOKEN_LIMIT + 1);

	logic [BYTE_W-1:0] acc_q [TOKEN_LIMIT];
	logic              neg_q [TOKEN_LIMIT];
	logic [CNT_W-1:0]  cnt_q;
	logic              in_tok_q;
	logic              stop_q;
	phase_t            phase_q;

	logic              live;
	logic              tok_byte;
	logic [CNT_W-1:0]  cnt_n;
	phase_t            phase_eff;
	logic [BYTE_W-1:0] cur_acc;
	logic [BYTE_W-1:0] digit;
	logic [BYTE_W-1:0] acc_x10;

	// Decode the current byte
	always_comb begin
		live      = ctl.vld && !stop_q;
		tok_byte  = live && (data != CH_NUL) && (data != CH_COMMA);
		cnt_n     = in_tok_q ? cnt_q : ((cnt_q == CNT_SAT) ? cnt_q : cnt_q + 1'b1);
		phase_eff = in_tok_q ? phase_q : PH_LEAD;
		digit     = data - CH_ZERO;
		cur_acc   = '0;
		for (int f = 0; f < TOKEN_LIMIT; f++) begin
			if (cnt_n == CNT_W'(f + 1)) cur_acc = cur_acc | acc_q[f];
		end
		acc_x10   = {cur_acc[BYTE_W-4:0], 3'b000} + {cur_acc[BYTE_W-2:0], 1'b0};
	end

	// Track token framing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			in_tok_q <= 1'b0;
			stop_q   <= 1'b0;
			phase_q  <= PH_LEAD;
		end else if (ctl.clear) begin
			cnt_q    <= '0;
			in_tok_q <= 1'b0;
			stop_q   <= 1'b0;
			phase_q  <= PH_LEAD;
		end else if (live) begin
			if (data == CH_NUL) begin
				stop_q <= 1'b1;
			end else if (data == CH_COMMA) begin
				in_tok_q <= 1'b0;
			end else begin
				in_tok_q <= 1'b1;
				cnt_q    <= cnt_n;
				if (cnt_n <= CNT_LIMIT) begin
					case (phase_eff)
						PH_LEAD: begin
							if (is_blank(data)) phase_q <= PH_LEAD;
							else if (data == CH_PLUS || data == CH_MINUS) phase_q <= PH_DIGITS;
							else if (is_digit(data)) phase_q <= PH_DIGITS;
							else phase_q <= PH_STOP;
						end
						PH_DIGITS: begin
							phase_q <= is_digit(data) ? PH_DIGITS : PH_STOP;
						end
						default: phase_q <= PH_STOP;
					endcase
				end else begin
					phase_q <= phase_eff;
				end
			end
		end
	end

	// Accumulate the value of the selected slot
	always_ff @(posedge clk) begin
		for (int f = 0; f < TOKEN_LIMIT; f++) begin
			if (ctl.clear) begin
				acc_q[f] <= '0;
				neg_q[f] <= 1'b0;
			end else if (tok_byte && cnt_n == CNT_W'(f + 1)) begin
				case (phase_eff)
					PH_LEAD: begin
						if (!is_blank(data) && (data == CH_PLUS || data == CH_MINUS)) begin
							neg_q[f] <= (data == CH_MINUS);
						end else if (is_digit(data)) begin
							acc_q[f] <= digit;
						end
					end
					PH_DIGITS: begin
						if (is_digit(data)) acc_q[f] <= acc_x10 + digit;
					end
					default: ;
				endcase
			end
		end
	end

	// Apply signs and pad unused fields
	for (genvar g = 0; g < OUT_FIELDS; g++) begin : g_field
		if (g < TOKEN_LIMIT) begin : g_used
			assign fields[g] = neg_q[g] ? (BYTE_W'(0) - acc_q[g]) : acc_q[g];
		end else begin : g_pad
			assign fields[g] = '0;
		end
	end

	assign tokens = (cnt_q > CNT_LIMIT) ? CNT_LIMIT : cnt_q;

endmodule

/* rtl/core/framed_decimal_record_parser.sv */
// Framed decimal record parser, top level: framing, record store, result register.
// Depends on frdp_pkg, frdp_if and frdp_scan.

// Bytes are taken one per cycle while receiving. Outside a frame every byte
// is dropped until the start marker; inside, each byte other than the end
// marker is written to a BUFFER_BYTES-deep store, the last slot absorbing any
// overflow. The end marker launches a walk over the stored record through the
// store's single read port, one byte per cycle: input is held off until the
// walk is over and one result is placed in the output register. The next
// frame is received while that result waits; a later end marker holds at the
// end of its walk until the register is free.

module framed_decimal_record_parser import frdp_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	parameter int FIELD_COUNT  = FIELD_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	frdp_rx_if.sink               rx,
	frdp_res_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_BYTES - 1);

	state_t            state_q, state_n;
	logic [BYTE_W-1:0] start_q, end_q;
	logic              in_frame_q;
	logic [AW-1:0]     widx_q, len_q, ptr_q;
	logic [BYTE_W-1:0] mem [BUFFER_BYTES];
	logic [BYTE_W-1:0] rd_data_s1;
	logic              rd_vld_s1;
	logic              res_valid_q;

	logic              rx_fire, is_end, is_data, issue, load;
	scan_ctl_t         scan_ctl;
	logic [BYTE_W-1:0] fields [OUT_FIELDS];
	logic [CNT_W-1:0]  tokens;

	assign rx.ready = (state_q == ST_RECV);
	assign rx_fire  = rx.valid && rx.ready;
	assign is_end   = in_frame_q && (rx.rx_byte == end_q);
	assign is_data  = in_frame_q && !is_end;
	assign issue    = (state_q == ST_PARSE) && (ptr_q != len_q);
	assign load     = (state_q == ST_FINISH) && (!res_valid_q || res.ready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_MARKER_RST;
			end_q   <= END_MARKER_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_START_MARKER: start_q <= cfg_data;
				REG_END_MARKER:   end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_RECV;
		else         state_q <= state_n;
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_RECV:   if (rx_fire && is_end) state_n = ST_PARSE;
			ST_PARSE:  if (ptr_q == len_q && !rd_vld_s1) state_n = ST_FINISH;
			ST_FINISH: if (load) state_n = ST_RECV;
			default:   state_n = ST_RECV;
		endcase
	end

	// Framing, write index and walk pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			widx_q     <= '0;
			len_q      <= '0;
			ptr_q      <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) ptr_q <= ptr_q + 1'b1;
			if (rx_fire) begin
				if (!in_frame_q) begin
					if (rx.rx_byte == start_q) in_frame_q <= 1'b1;
				end else if (is_end) begin
					in_frame_q <= 1'b0;
					len_q      <= widx_q;
					widx_q     <= '0;
					ptr_q      <= '0;
				end else begin
					widx_q <= (widx_q == LAST_IDX) ? LAST_IDX : widx_q + 1'b1;
				end
			end
		end
	end

	// Record store: write incoming data, read during the walk
	always_ff @(posedge clk) begin
		if (rx_fire && is_data) mem[widx_q] <= rx.rx_byte;
		if (issue) rd_data_s1 <= mem[ptr_q];
	end

	assign scan_ctl.clear = rx_fire && is_end;
	assign scan_ctl.vld   = rd_vld_s1;

	frdp_scan #(
		.FIELD_COUNT(FIELD_COUNT)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.data   (rd_data_s1),
		.fields (fields),
		.tokens (tokens)
	);

	// Result register: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                 res_valid_q <= 1'b0;
		else if (load)               res_valid_q <= 1'b1;
		else if (res.ready)          res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res.selected_output <= fields[0];
			res.cpu_util        <= fields[1];
			res.ram_util        <= fields[2];
			res.cpu_temp        <= fields[3];
			res.gpu_temp        <= fields[4];
			res.manual_value    <= fields[5];
			res.tokens_found    <= tokens;
		end
	end

	assign res.valid = res_valid_q;

endmodule
